>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the billboard modelview transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property that is ignored while reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds across reset.
`define ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/bmt_pkg.sv
// Shared types, constants and fixed-point helpers of the billboard transform.
`timescale 1ns / 1ps
package bmt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int NUM_VIEW_REGS = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;

    localparam int Q30_SH = 30;
    localparam logic [30:0] Q30_ONE = 31'(64'd1 << Q30_SH);
    localparam logic [31:0] DEG_TO_RAD_Q30 = 32'd18740330;

    // Reciprocal of 360 for the angle wrap; exact floor for the offset range used.
    localparam int RECIP_360_SH = 40;
    localparam logic [31:0] RECIP_360 = 32'(((64'd1 << RECIP_360_SH) + 64'd359) / 64'd360);

    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam int SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};

    localparam logic [1:0] COL_LAST = 2'd3;

    typedef logic [WORD_W-1:0] word_t;
    // Indexed [column][row].
    typedef word_t [3:0][3:0] mat_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t scale;
    } bmt_tag_t;

    // Fixed-point product rounded to nearest, ties toward plus infinity.
    function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int f);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return (p + (64'sd1 <<< (f - 1))) >>> f;
    endfunction

    function automatic word_t sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> rtl/bmt_horner_step.sv
// One step of the Horner series: h_out = 1 - ((x2 * h_in) >> 30) / DIV in Q.30.
`timescale 1ns / 1ps
module bmt_horner_step
    import bmt_pkg::*;
#(
    parameter int DIV = 2
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [29:0] x2_in,
    input  logic [30:0] h_in,
    output logic [29:0] x2_out,
    output logic [30:0] h_out
);

    localparam int SH = Q30_SH + $clog2(DIV);
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [29:0] t_reg, t_next;
    logic [29:0] x2a_reg;
    logic [30:0] h_reg, h_next;
    logic [29:0] x2b_reg;

    assign t_next = 30'((64'(x2_in) * 64'(h_in)) >> Q30_SH);
    // The quotient comes from a reciprocal multiply that is exact for t below 2^30.
    assign h_next = Q30_ONE - 31'((64'(t_reg) * RECIP) >> SH);

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= t_next;
            x2a_reg <= x2_in;
            h_reg   <= h_next;
            x2b_reg <= x2a_reg;
        end
    end

    assign x2_out = x2b_reg;
    assign h_out  = h_reg;

endmodule

>>> rtl/bmt_sincos.sv
// Angle reduction and series sine and cosine, sixteen register stages.
`timescale 1ns / 1ps
module bmt_sincos
    import bmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  word_t    angle,
    input  bmt_tag_t tag_in,
    output logic     out_valid,
    output word_t    sin_out,
    output word_t    cos_out,
    output bmt_tag_t tag_out
);

    localparam int REM_W = 7 + FRAC_BITS;
    localparam int QW    = 32 - 8;
    localparam int SB_N  = 2 * COS_STEPS;
    localparam logic [31:0] OFF = 32'(64'd360 * (64'd1 << (31 - FRAC_BITS)));
    localparam logic [REM_W-1:0] Q45 = REM_W'(64'd45 << FRAC_BITS);
    localparam logic [REM_W-1:0] Q90 = REM_W'(64'd90 << FRAC_BITS);
    localparam logic [31:0] RND = 32'(64'd1 << (29 - FRAC_BITS));

    // Stage 1: offset the integer degrees so the wrap works on a positive value.
    logic                 v1_reg;
    logic [31:0]          u1_reg;
    logic [FRAC_BITS-1:0] lo1_reg;
    bmt_tag_t             tag1_reg;
    // Stage 2: quotient by 360.
    logic                 v2_reg;
    logic [QW-1:0]        qe2_reg;
    logic [31:0]          u2_reg;
    logic [FRAC_BITS-1:0] lo2_reg;
    bmt_tag_t             tag2_reg;
    // Stage 3: quadrant and folded remainder.
    logic                 v3_reg;
    logic [REM_W-1:0]     rem3_reg, rem3_next;
    logic [1:0]           quad3_reg, quad3_next;
    logic                 swap3_reg, swap3_next;
    bmt_tag_t             tag3_reg;
    // Stage 4: radians in Q.30.
    logic                 v4_reg;
    logic [29:0]          x4_reg;
    logic [1:0]           quad4_reg;
    logic                 swap4_reg;
    bmt_tag_t             tag4_reg;
    // Stage 5: x squared.
    logic                 v5_reg;
    logic [29:0]          x5_reg, x2_5_reg;
    logic [1:0]           quad5_reg;
    logic                 swap5_reg;
    bmt_tag_t             tag5_reg;

    logic [63:0] prod360;
    logic [8:0]  r360;
    logic [6:0]  deg_in_quad;
    logic [REM_W-1:0] rem_raw;

    assign prod360 = 64'(u1_reg) * 64'(RECIP_360);
    assign r360 = 9'(u2_reg - 32'(qe2_reg) * 32'd360);

    always_comb begin
        priority if (r360 >= 9'd270) begin
            quad3_next  = 2'd3;
            deg_in_quad = 7'(r360 - 9'd270);
        end else if (r360 >= 9'd180) begin
            quad3_next  = 2'd2;
            deg_in_quad = 7'(r360 - 9'd180);
        end else if (r360 >= 9'd90) begin
            quad3_next  = 2'd1;
            deg_in_quad = 7'(r360 - 9'd90);
        end else begin
            quad3_next  = 2'd0;
            deg_in_quad = 7'(r360);
        end
        rem_raw    = {deg_in_quad, lo2_reg};
        swap3_next = rem_raw > Q45;
        rem3_next  = swap3_next ? (Q90 - rem_raw) : rem_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg    <= 32'($signed(angle) >>> FRAC_BITS) + OFF;
            lo1_reg   <= angle[FRAC_BITS-1:0];
            tag1_reg  <= tag_in;
            qe2_reg   <= prod360[RECIP_360_SH +: QW];
            u2_reg    <= u1_reg;
            lo2_reg   <= lo1_reg;
            tag2_reg  <= tag1_reg;
            rem3_reg  <= rem3_next;
            quad3_reg <= quad3_next;
            swap3_reg <= swap3_next;
            tag3_reg  <= tag2_reg;
            x4_reg    <= 30'((64'(rem3_reg) * 64'(DEG_TO_RAD_Q30)) >> FRAC_BITS);
            quad4_reg <= quad3_reg;
            swap4_reg <= swap3_reg;
            tag4_reg  <= tag3_reg;
            x5_reg    <= x4_reg;
            x2_5_reg  <= 30'((64'(x4_reg) * 64'(x4_reg)) >> Q30_SH);
            quad5_reg <= quad4_reg;
            swap5_reg <= swap4_reg;
            tag5_reg  <= tag4_reg;
        end
    end

    // Series section: sideband delay line runs beside the Horner steps.
    logic       sb_valid_reg [SB_N];
    logic [1:0] sb_quad_reg  [SB_N];
    logic       sb_swap_reg  [SB_N];
    bmt_tag_t   sb_tag_reg   [SB_N];
    logic [29:0] sb_x_reg    [2 * SIN_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SB_N; i++) begin
                sb_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            sb_valid_reg[0] <= v5_reg;
            for (int i = 1; i < SB_N; i++) begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_quad_reg[0] <= quad5_reg;
            sb_swap_reg[0] <= swap5_reg;
            sb_tag_reg[0]  <= tag5_reg;
            sb_x_reg[0]    <= x5_reg;
            for (int i = 1; i < SB_N; i++) begin
                sb_quad_reg[i] <= sb_quad_reg[i-1];
                sb_swap_reg[i] <= sb_swap_reg[i-1];
                sb_tag_reg[i]  <= sb_tag_reg[i-1];
            end
            for (int i = 1; i < 2 * SIN_STEPS; i++) begin
                sb_x_reg[i] <= sb_x_reg[i-1];
            end
        end
    end

    logic [29:0] sin_x2 [SIN_STEPS];
    logic [30:0] sin_h  [SIN_STEPS];
    logic [29:0] cos_x2 [COS_STEPS];
    logic [30:0] cos_h  [COS_STEPS];

    for (genvar j = 0; j < SIN_STEPS; j++) begin : g_sin
        bmt_horner_step #(.DIV(SIN_DIV[j])) u_step (
            .aclk   (aclk),
            .en     (en),
            .x2_in  ((j == 0) ? x2_5_reg : sin_x2[(j == 0) ? 0 : j - 1]),
            .h_in   ((j == 0) ? Q30_ONE : sin_h[(j == 0) ? 0 : j - 1]),
            .x2_out (sin_x2[j]),
            .h_out  (sin_h[j])
        );
    end

    for (genvar j = 0; j < COS_STEPS; j++) begin : g_cos
        bmt_horner_step #(.DIV(COS_DIV[j])) u_step (
            .aclk   (aclk),
            .en     (en),
            .x2_in  ((j == 0) ? x2_5_reg : cos_x2[(j == 0) ? 0 : j - 1]),
            .h_in   ((j == 0) ? Q30_ONE : cos_h[(j == 0) ? 0 : j - 1]),
            .x2_out (cos_x2[j]),
            .h_out  (cos_h[j])
        );
    end

    // Sine needs one more multiply by x; the second register keeps it level with cosine.
    logic [29:0] sin_a_reg, sin_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_a_reg <= 30'((64'(sb_x_reg[2 * SIN_STEPS - 1]) * 64'(sin_h[SIN_STEPS-1]))
                             >> Q30_SH);
            sin_b_reg <= sin_a_reg;
        end
    end

    // Final stage: round to the output format, undo the fold, apply the quadrant.
    word_t s_rnd, c_rnd, s_sw, c_sw, s_next, c_next;
    logic        vo_reg;
    word_t       s_reg, c_reg;
    bmt_tag_t    tago_reg;

    assign s_rnd = (32'(sin_b_reg) + RND) >> (30 - FRAC_BITS);
    assign c_rnd = (32'(cos_h[COS_STEPS-1]) + RND) >> (30 - FRAC_BITS);
    assign s_sw  = sb_swap_reg[SB_N-1] ? c_rnd : s_rnd;
    assign c_sw  = sb_swap_reg[SB_N-1] ? s_rnd : c_rnd;

    always_comb begin
        unique case (sb_quad_reg[SB_N-1])
            2'd0: begin
                s_next = s_sw;
                c_next = c_sw;
            end
            2'd1: begin
                s_next = c_sw;
                c_next = -s_sw;
            end
            2'd2: begin
                s_next = -s_sw;
                c_next = -c_sw;
            end
            default: begin
                s_next = -c_sw;
                c_next = s_sw;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= sb_valid_reg[SB_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= s_next;
            c_reg    <= c_next;
            tago_reg <= sb_tag_reg[SB_N-1];
        end
    end

    assign out_valid = vo_reg;
    assign sin_out   = s_reg;
    assign cos_out   = c_reg;
    assign tag_out   = tago_reg;

endmodule

>>> rtl/bmt_rotscale.sv
// Builds the billboard model matrix: view transpose, z rotation, scale, position.
`timescale 1ns / 1ps
module bmt_rotscale
    import bmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  word_t    sin_in,
    input  word_t    cos_in,
    input  bmt_tag_t tag_in,
    input  mat_t     view,
    output logic     out_valid,
    output mat_t     m_out
);

    localparam int PW = 64 - FRAC_BITS;
    localparam word_t ONE_Q = 32'(64'd1 << FRAC_BITS);

    // Stage 1: the four rotation products of each row.
    logic                 v1_reg;
    logic signed [PW-1:0] cm0_reg [3];
    logic signed [PW-1:0] sm1_reg [3];
    logic signed [PW-1:0] cm1_reg [3];
    logic signed [PW-1:0] sm0_reg [3];
    word_t                col2_1_reg [3];
    bmt_tag_t             tag1_reg;
    // Stage 2: rotated columns.
    logic                 v2_reg;
    word_t                rot_reg [2][3];
    word_t                col2_2_reg [3];
    bmt_tag_t             tag2_reg;
    // Stage 3: scale products.
    logic                 v3_reg;
    logic signed [PW-1:0] sc_reg [3][3];
    bmt_tag_t             tag3_reg;
    // Stage 4: saturated model matrix.
    logic                 v4_reg;
    mat_t                 m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Model column c, row r is view column r, row c.
            for (int r = 0; r < 3; r++) begin
                cm0_reg[r]    <= PW'(qmul(cos_in, view[r][0], FRAC_BITS));
                sm1_reg[r]    <= PW'(qmul(sin_in, view[r][1], FRAC_BITS));
                cm1_reg[r]    <= PW'(qmul(cos_in, view[r][1], FRAC_BITS));
                sm0_reg[r]    <= PW'(qmul(sin_in, view[r][0], FRAC_BITS));
                col2_1_reg[r] <= view[r][2];
            end
            tag1_reg <= tag_in;

            for (int r = 0; r < 3; r++) begin
                rot_reg[0][r] <= sat32(64'(cm0_reg[r]) + 64'(sm1_reg[r]));
                rot_reg[1][r] <= sat32(64'(cm1_reg[r]) - 64'(sm0_reg[r]));
                col2_2_reg[r] <= col2_1_reg[r];
            end
            tag2_reg <= tag1_reg;

            for (int r = 0; r < 3; r++) begin
                sc_reg[0][r] <= PW'(qmul(rot_reg[0][r], tag2_reg.scale, FRAC_BITS));
                sc_reg[1][r] <= PW'(qmul(rot_reg[1][r], tag2_reg.scale, FRAC_BITS));
                sc_reg[2][r] <= PW'(qmul(col2_2_reg[r], tag2_reg.scale, FRAC_BITS));
            end
            tag3_reg <= tag2_reg;

            // Row 3 of the first three columns is zero, and zero stays zero.
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    m_reg[c][r] <= sat32(64'(sc_reg[c][r]));
                end
                m_reg[c][3] <= '0;
            end
            m_reg[3][0] <= tag3_reg.pos_x;
            m_reg[3][1] <= tag3_reg.pos_y;
            m_reg[3][2] <= tag3_reg.pos_z;
            m_reg[3][3] <= ONE_Q;
        end
    end

    assign out_valid = v4_reg;
    assign m_out     = m_reg;

endmodule

>>> rtl/bmt_colgen.sv
// Forms view times model matrix, one column per cycle when not stalled.
`timescale 1ns / 1ps
module bmt_colgen
    import bmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  mat_t       m_in,
    input  mat_t       view,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] column_index,
    output logic       last_column,
    output word_t      elem [4]
);

    localparam int PW = 64 - FRAC_BITS;

    logic       en;
    logic       hold_valid_reg, hold_valid_next;
    logic [1:0] cnt_reg, cnt_next;
    mat_t       hold_mat_reg;
    logic       take;

    logic                 p_valid_reg;
    logic [1:0]           p_col_reg;
    logic signed [PW-1:0] p_prod_reg [4][4];

    logic       o_valid_reg;
    logic [1:0] o_col_reg;
    word_t      o_elem_reg [4];

    assign en       = !o_valid_reg || m_ready;
    assign in_ready = !hold_valid_reg || (en && (cnt_reg == COL_LAST));
    assign take     = in_valid && in_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        if (en && hold_valid_reg) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == COL_LAST) begin
                hold_valid_next = 1'b0;
            end
        end
        if (take) begin
            hold_valid_next = 1'b1;
            cnt_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            p_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            if (en) begin
                p_valid_reg <= hold_valid_reg;
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hold_mat_reg <= m_in;
        end
        if (en) begin
            p_col_reg <= cnt_reg;
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    p_prod_reg[r][k] <= PW'(qmul(view[k][r], hold_mat_reg[cnt_reg][k],
                                                 FRAC_BITS));
                end
            end
            o_col_reg <= p_col_reg;
            for (int r = 0; r < 4; r++) begin
                o_elem_reg[r] <= sat32(64'(p_prod_reg[r][0]) + 64'(p_prod_reg[r][1])
                                     + 64'(p_prod_reg[r][2]) + 64'(p_prod_reg[r][3]));
            end
        end
    end

    assign m_valid      = o_valid_reg;
    assign column_index = o_col_reg;
    assign last_column  = (o_col_reg == COL_LAST);
    assign elem         = o_elem_reg;

`include "assert_macros.svh"

    `ASSERT_AT(a_hold_kept, aclk, aresetn, hold_valid_reg && (cnt_reg != COL_LAST) |=> hold_valid_reg, "item left the column generator early")
    `ASSERT_AT(a_cnt_idle, aclk, aresetn, !hold_valid_reg |-> (cnt_reg == 2'd0), "column count moved without an item")
    `ASSERT_AT(a_p_kept, aclk, aresetn, p_valid_reg && !en |=> p_valid_reg, "product stage lost an item in a stall")
    `ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !hold_valid_reg && !o_valid_reg, "reset did not clear the column generator")

endmodule

>>> rtl/billboard_modelview_transform_top.sv
// Top level of the spherical billboard modelview transform.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   pos_x, pos_y, pos_z, angle_deg, scale_factor
// m_       out        m_valid / m_ready   column_index, last_column, elem_row0..3
// cfg_     in         cfg_wr_en           cfg_index, cfg_wr_data (view matrix halves)
//
// Each item yields four column items; the column generator forms one column per
// cycle on its sixteen multipliers while m_ready does not stall it, and takes
// the next item as the last column of the one before moves on. Each item passes
// the angle reduction and the sine and cosine series, the model matrix, then
// the hold, product and sum registers. Reset clears all valid bits and the view
// matrix to zero. When m_ready is low with a column on the output, the column
// generator holds its stages in place. The front pipeline keeps moving until
// its last stage holds an item that the column generator cannot take, and then
// all of it stalls under one enable; nothing is lost or repeated.
module billboard_modelview_transform_top
    import bmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    input  logic signed [31:0]    s_angle_deg,
    input  logic signed [31:0]    s_scale_factor,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_column_index,
    output logic                  m_last_column,
    output logic signed [31:0]    m_elem_row0,
    output logic signed [31:0]    m_elem_row1,
    output logic signed [31:0]    m_elem_row2,
    output logic signed [31:0]    m_elem_row3
);

    // View matrix registers: register 2c+h holds column c, rows 2h (low) and 2h+1 (high).
    logic [CFG_DATA_W-1:0] view_reg [NUM_VIEW_REGS];
    mat_t                  view_mat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VIEW_REGS; i++) begin
                view_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_VIEW_REGS))) begin
            // Writes past the last register are dropped.
            view_reg[cfg_index[2:0]] <= cfg_wr_data;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                view_mat[c][r] = view_reg[c * 2 + r / 2][(r % 2) * WORD_W +: WORD_W];
            end
        end
    end

    // The front pipeline moves whenever its last stage is empty or the column
    // generator takes that stage's item.
    logic     front_en;
    logic     sc_valid;
    word_t    sc_sin, sc_cos;
    bmt_tag_t sc_tag, in_tag;
    logic     rs_valid;
    mat_t     rs_mat;
    logic     col_ready;
    word_t    col_elem [4];

    assign front_en = !rs_valid || col_ready;
    assign s_ready  = front_en;

    assign in_tag.pos_x = s_pos_x;
    assign in_tag.pos_y = s_pos_y;
    assign in_tag.pos_z = s_pos_z;
    assign in_tag.scale = s_scale_factor;

    bmt_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (front_en),
        .in_valid  (s_valid),
        .angle     (s_angle_deg),
        .tag_in    (in_tag),
        .out_valid (sc_valid),
        .sin_out   (sc_sin),
        .cos_out   (sc_cos),
        .tag_out   (sc_tag)
    );

    bmt_rotscale #(.FRAC_BITS(FRAC_BITS)) u_rotscale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (front_en),
        .in_valid  (sc_valid),
        .sin_in    (sc_sin),
        .cos_in    (sc_cos),
        .tag_in    (sc_tag),
        .view      (view_mat),
        .out_valid (rs_valid),
        .m_out     (rs_mat)
    );

    bmt_colgen #(.FRAC_BITS(FRAC_BITS)) u_colgen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (rs_valid),
        .in_ready     (col_ready),
        .m_in         (rs_mat),
        .view         (view_mat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .column_index (m_column_index),
        .last_column  (m_last_column),
        .elem         (col_elem)
    );

    assign m_elem_row0 = col_elem[0];
    assign m_elem_row1 = col_elem[1];
    assign m_elem_row2 = col_elem[2];
    assign m_elem_row3 = col_elem[3];

endmodule
